>>> rtl/core/avs2p_pkg.sv
package avs2p_pkg;

    // Width of the saturating sequence, picture and gap counters.
    localparam int COUNT_BITS = 16;
    localparam int FIELD_BITS = 16;

    localparam logic [31:0] SEQ_HDR_WORD = 32'h0000_01B0;
    localparam logic [23:0] START_PREFIX = 24'h00_0001;

    localparam logic [7:0] CODE_SEQ_HDR = 8'hB0;
    localparam logic [7:0] CODE_SEQ_END = 8'hB1;
    localparam logic [7:0] CODE_USER    = 8'hB2;
    localparam logic [7:0] CODE_PIC_I   = 8'hB3;
    localparam logic [7:0] CODE_EXT     = 8'hB5;
    localparam logic [7:0] CODE_PIC_PB  = 8'hB6;
    localparam logic [7:0] CODE_VID_EDIT = 8'hB7;

    localparam logic [7:0] PROF_MAIN_PIC = 8'h20;
    localparam logic [7:0] PROF_MAIN     = 8'h22;
    localparam logic [7:0] PROF_MAIN10_A = 8'h30;
    localparam logic [7:0] PROF_MAIN10_B = 8'h32;

    typedef logic [COUNT_BITS-1:0] t_cnt;
    typedef logic [FIELD_BITS-1:0] t_field;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic   detected;
        t_field sequence_count;
        t_field picture_count;
        t_field header_gap;
    } t_out;

    function automatic logic is_profile(input logic [7:0] b);
        return b inside {PROF_MAIN_PIC, PROF_MAIN, PROF_MAIN10_A, PROF_MAIN10_B};
    endfunction

    function automatic logic is_unit(input logic [7:0] c);
        return c inside {CODE_SEQ_HDR, CODE_SEQ_END, CODE_USER, CODE_PIC_I,
                         CODE_EXT, CODE_PIC_PB, CODE_VID_EDIT};
    endfunction

    function automatic t_cnt sat_inc(input t_cnt v);
        return (&v) ? v : t_cnt'(v + t_cnt'(1));
    endfunction

    function automatic t_field to_field(input t_cnt v);
        logic [31:0] wide;
        wide = 32'(v);
        return wide[FIELD_BITS-1:0];
    endfunction

endpackage

>>> rtl/core/avs2p_scan.sv
module avs2p_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  avs2p_pkg::t_in      i_item,
    input  avs2p_pkg::t_field   i_min_gap,
    output avs2p_pkg::t_out     o_res
);

    logic [31:0]     r_window,  n_window;
    logic [2:0]      r_lead,    n_lead;
    logic            r_rejected, n_rejected;
    logic            r_end_seen, n_end_seen;
    logic            r_prof_pend, n_prof_pend;
    logic            r_hdr_found, n_hdr_found;
    avs2p_pkg::t_cnt r_gap,     n_gap;
    avs2p_pkg::t_cnt r_gap_cap, n_gap_cap;
    avs2p_pkg::t_cnt r_seq,     n_seq;
    avs2p_pkg::t_cnt r_pic,     n_pic;
    logic            stop;
    logic [7:0]      b;

    assign b = i_item.data_byte;

    always_comb begin
        n_window    = r_window;
        n_lead      = r_lead;
        n_rejected  = r_rejected;
        n_end_seen  = r_end_seen;
        n_prof_pend = r_prof_pend;
        n_hdr_found = r_hdr_found;
        n_gap       = r_gap;
        n_gap_cap   = r_gap_cap;
        n_seq       = r_seq;
        n_pic       = r_pic;
        stop        = 1'b0;
        if (!(r_rejected || r_end_seen)) begin
            n_window = {r_window[23:0], b};
            if (!r_lead[2]) begin
                n_lead = r_lead + 3'd1;
                if (n_lead[2] && n_window != avs2p_pkg::SEQ_HDR_WORD) begin
                    n_rejected = 1'b1;
                    stop       = 1'b1;
                end
            end
            if (!stop && r_prof_pend) begin
                n_prof_pend = 1'b0;
                if (!avs2p_pkg::is_profile(b)) begin
                    n_rejected = 1'b1;
                    stop       = 1'b1;
                end
            end
            if (!stop) begin
                if (r_hdr_found) begin
                    n_gap = avs2p_pkg::sat_inc(r_gap);
                end
                if (n_window[31:8] == avs2p_pkg::START_PREFIX && avs2p_pkg::is_unit(b)) begin
                    // gap is latched once, on the first unit code after a header
                    if (r_hdr_found && r_gap_cap == '0) begin
                        n_gap_cap = n_gap;
                    end
                    case (b)
                        avs2p_pkg::CODE_SEQ_HDR: begin
                            n_prof_pend = 1'b1;
                            n_hdr_found = 1'b1;
                            n_gap       = '0;
                            n_seq       = avs2p_pkg::sat_inc(r_seq);
                        end
                        avs2p_pkg::CODE_PIC_I, avs2p_pkg::CODE_PIC_PB: begin
                            n_pic = avs2p_pkg::sat_inc(r_pic);
                        end
                        avs2p_pkg::CODE_SEQ_END: begin
                            n_end_seen = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    // verdict as it stands after this byte
    always_comb begin
        o_res.detected = !n_rejected && n_lead[2] && !n_prof_pend &&
                         (n_seq != '0) && (n_pic != '0) &&
                         (32'(n_gap_cap) >= 32'(i_min_gap));
        o_res.sequence_count = avs2p_pkg::to_field(n_seq);
        o_res.picture_count  = avs2p_pkg::to_field(n_pic);
        o_res.header_gap     = avs2p_pkg::to_field(n_gap_cap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_item.last_byte)) begin
            r_window    <= '1;
            r_lead      <= '0;
            r_rejected  <= 1'b0;
            r_end_seen  <= 1'b0;
            r_prof_pend <= 1'b0;
            r_hdr_found <= 1'b0;
            r_gap       <= '0;
            r_gap_cap   <= '0;
            r_seq       <= '0;
            r_pic       <= '0;
        end else if (i_en) begin
            r_window    <= n_window;
            r_lead      <= n_lead;
            r_rejected  <= n_rejected;
            r_end_seen  <= n_end_seen;
            r_prof_pend <= n_prof_pend;
            r_hdr_found <= n_hdr_found;
            r_gap       <= n_gap;
            r_gap_cap   <= n_gap_cap;
            r_seq       <= n_seq;
            r_pic       <= n_pic;
        end
    end

endmodule

>>> rtl/core/avs2_stream_probe_top.sv
// AVS2 stream probe. Bytes of a probe buffer enter one per request on the
// input channel; the block slides a 32-bit window over them to find
// 00 00 01 xx start codes, checks that the buffer opens with a sequence
// header and that every sequence header is followed by an allowed profile
// byte, counts sequence headers and pictures (saturating), and measures the
// header gap. Scanning halts at the sequence end code. The request flagged
// last_byte yields exactly one verdict request on the output channel and
// returns all stream state to its reset value, so the next byte starts a
// fresh buffer; min_header_gap (reset 21) survives. The scan state updates
// in one pass per byte, and a byte is accepted each clock as long as the
// one-deep verdict register is not held by a stalled output. Write
// min_header_gap only while the block is idle.
module avs2_stream_probe_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte input
    input  logic               i_in_valid,
    input  avs2p_pkg::t_in     i_in_data,
    output logic               o_in_stall,
    // verdict output
    output logic               o_out_valid,
    output avs2p_pkg::t_out    o_out_data,
    input  logic               i_out_stall,
    // configuration
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata
);

    avs2p_pkg::t_field r_min_gap;
    avs2p_pkg::t_out   r_out;
    logic              r_out_valid;
    avs2p_pkg::t_out   scan_res;
    logic              in_acc;

    // only a held verdict blocks the input; a draining one does not
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap <= avs2p_pkg::t_field'(21);
        end else if (i_cfg_we) begin
            r_min_gap <= i_cfg_wdata;
        end
    end

    avs2p_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (in_acc),
        .i_item    (i_in_data),
        .i_min_gap (r_min_gap),
        .o_res     (scan_res)
    );

    // verdict register: loaded on the last byte of a buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_in_data.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.last_byte) begin
            r_out <= scan_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> test/avs2_stream_probe_top_test.sv
`timescale 1ns / 100ps

module avs2_stream_probe_top_test;
    import avs2p_pkg::*;

    localparam int     RESET_CYCLES  = 7;
    localparam int     DRAIN_CYCLES  = 8;
    localparam int     HOLD_CYCLES   = 120;
    localparam int     RANDOM_BYTES  = 780;
    localparam int     TAIL_BYTES    = 100;
    localparam int     HOLD_STREAM   = 5;
    localparam int     LEAD_BYTES    = 4;
    localparam t_field MIN_GAP_RESET = 16'd21;

    // Predicts the verdict of each probe buffer and holds the verdicts
    // still to come out of the block, oldest first.
    class probe_verdict_board;
        logic [31:0] window;
        int unsigned lead_seen;
        bit          rejected;
        bit          end_hit;
        bit          profile_due;
        bit          header_hit;
        t_cnt        gap_run;
        t_cnt        gap_held;
        t_cnt        seq_n;
        t_cnt        pic_n;
        t_field      min_gap;
        t_out        verdicts_due[$];
        int          errors;

        function new();
            min_gap = MIN_GAP_RESET;
            errors  = 0;
            restart();
        endfunction

        function void restart();
            window      = '1;
            lead_seen   = 0;
            rejected    = 1'b0;
            end_hit     = 1'b0;
            profile_due = 1'b0;
            header_hit  = 1'b0;
            gap_run     = '0;
            gap_held    = '0;
            seq_n       = '0;
            pic_n       = '0;
        endfunction

        function t_cnt bump(t_cnt v);
            return (&v) ? v : t_cnt'(v + 1'b1);
        endfunction

        function void advance_window(logic [7:0] b);
            logic [7:0] kind;
            if (rejected || end_hit)
                return;
            window = {window[23:0], b};
            if (lead_seen < LEAD_BYTES) begin
                lead_seen++;
                if (lead_seen == LEAD_BYTES && window != SEQ_HDR_WORD) begin
                    rejected = 1'b1;
                    return;
                end
            end
            if (profile_due) begin
                profile_due = 1'b0;
                if (!(b inside {PROF_MAIN_PIC, PROF_MAIN, PROF_MAIN10_A, PROF_MAIN10_B})) begin
                    rejected = 1'b1;
                    return;
                end
            end
            if (header_hit)
                gap_run = bump(gap_run);
            if (window[31:8] != START_PREFIX)
                return;
            kind = window[7:0];
            if (!(kind inside {CODE_SEQ_HDR, CODE_SEQ_END, CODE_USER, CODE_PIC_I,
                               CODE_EXT, CODE_PIC_PB, CODE_VID_EDIT}))
                return;
            if (header_hit && gap_held == '0)
                gap_held = gap_run;
            case (kind)
                CODE_SEQ_HDR: begin
                    profile_due = 1'b1;
                    header_hit  = 1'b1;
                    gap_run     = '0;
                    seq_n       = bump(seq_n);
                end
                CODE_PIC_I, CODE_PIC_PB: pic_n = bump(pic_n);
                CODE_SEQ_END: end_hit = 1'b1;
                default: ;
            endcase
        endfunction

        function void take_byte(t_in req);
            t_out v;
            advance_window(req.data_byte);
            if (!req.last_byte)
                return;
            v.detected = !rejected && lead_seen >= LEAD_BYTES && !profile_due &&
                         seq_n != '0 && pic_n != '0 && gap_held >= min_gap;
            v.sequence_count = t_field'(seq_n);
            v.picture_count  = t_field'(pic_n);
            v.header_gap     = t_field'(gap_held);
            verdicts_due.push_back(v);
            restart();
        endfunction

        function void compare_field(string field_name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, field_name, want, got);
                errors++;
            end
        endfunction

        function void check_verdict(t_out got);
            t_out want;
            if (verdicts_due.size() == 0) begin
                $display("%0t: verdict with none expected, got det=%0d seq=%0d pic=%0d gap=%0d",
                         $time, got.detected, got.sequence_count, got.picture_count,
                         got.header_gap);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            compare_field("detected", 16'(want.detected), 16'(got.detected));
            compare_field("sequence_count", want.sequence_count, got.sequence_count);
            compare_field("picture_count", want.picture_count, got.picture_count);
            compare_field("header_gap", want.header_gap, got.header_gap);
        endfunction
    endclass

    logic        i_clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in         in_data   = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out        o_out_data;
    logic        out_stall = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;

    // pacing controls for the stimulus and the receiver
    bit tx_idle  = 1'b0;
    bit rx_idle  = 1'b0;
    bit hold_out = 1'b0;
    bit out_held = 1'b0;

    probe_verdict_board board;
    logic [7:0]         pending_bytes[$];

    avs2_stream_probe_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop, several times the slowest legal run of about a thousand bytes.
    initial begin
        #1ms;
        $display("avs2_stream_probe_top_test: FAIL");
        $finish;
    end

    // Receiver: random stall bursts, or one long hold-off on request so the
    // verdict register fills and the block pushes back on its input.
    initial begin
        forever begin
            if (hold_out) begin
                out_stall <= 1'b1;
                out_held = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_out = 1'b0;
                out_held = 1'b0;
            end else if (rx_idle && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // Output monitor: values read just after the edge are the ones the
    // edge saw, so a verdict request is taken exactly when it was accepted.
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && !out_stall)
            board.check_verdict(o_out_data);
    end

    // One byte request; returns on the edge that accepted it. Valid stays
    // high afterwards, so any caller that lets an edge pass must drop it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (tx_idle && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= t_in'{data_byte: b, last_byte: last};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.take_byte(in_data);
    endtask

    // Sends the queued buffer, last_byte on its final byte.
    task automatic send_pending();
        int n;
        n = pending_bytes.size();
        for (int k = 0; k < n; k++)
            send_byte(pending_bytes[k], k == n - 1);
        pending_bytes.delete();
    endtask

    // Input quiet, every verdict back, then a drain wait for bytes that
    // raise no verdict to work through.
    task automatic settle();
        in_valid <= 1'b0;
        while (board.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_min_gap(input t_field v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        board.min_gap = v;
    endtask

    function automatic void put_code(input logic [7:0] kind);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'h01);
        pending_bytes.push_back(kind);
    endfunction

    function automatic void put_profile(input bit good);
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0: b = PROF_MAIN_PIC;
            1: b = PROF_MAIN;
            2: b = PROF_MAIN10_A;
            default: b = PROF_MAIN10_B;
        endcase
        pending_bytes.push_back(good ? b : 8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_filler(input int n);
        repeat (n) pending_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Mostly real unit codes, pictures weighted up, now and then any byte.
    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 9))
            0: return CODE_SEQ_HDR;
            1: return CODE_SEQ_END;
            2: return CODE_USER;
            3, 4: return CODE_PIC_I;
            5: return CODE_EXT;
            6, 7: return CODE_PIC_PB;
            8: return CODE_VID_EDIT;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_field pick_min_gap();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 16'd1;
            2: return MIN_GAP_RESET;
            3: return 16'($urandom_range(0, 40));
            default: return '1;
        endcase
    endfunction

    // Random probe buffer: mostly well-formed streams with random content,
    // the rest plain noise, a corrupted opening, a cut header or a bad
    // profile byte.
    function automatic void build_random_buffer();
        int         flavour;
        logic [7:0] code;
        pending_bytes.delete();
        flavour = $urandom_range(0, 9);
        if (flavour == 0) begin
            put_filler($urandom_range(1, 12));
            return;
        end
        put_code(CODE_SEQ_HDR);
        if (flavour == 1) begin
            // ends on the header itself, or a random byte where the profile goes
            if ($urandom_range(0, 1) == 1)
                put_profile(1'b0);
            return;
        end
        put_profile($urandom_range(0, 15) != 0);
        repeat ($urandom_range(1, 6)) begin
            put_filler(($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(0, 6));
            code = pick_code();
            put_code(code);
            if (code == CODE_SEQ_HDR)
                put_profile($urandom_range(0, 7) != 0);
        end
        put_filler($urandom_range(0, 4));
        if (flavour == 2)
            pending_bytes[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int sent;
        int streams;
        board = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: short buffer, missing and bad profile, then a good
        // stream either side of the gap threshold.
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        pending_bytes.push_back(8'hFF);
        send_pending();
        put_code(CODE_SEQ_HDR);
        send_pending();
        put_code(CODE_SEQ_HDR);
        pending_bytes.push_back(8'h31);
        send_pending();
        put_code(CODE_SEQ_HDR);
        pending_bytes.push_back(PROF_MAIN);
        put_code(CODE_PIC_PB);
        send_pending();
        write_min_gap('0);
        put_code(CODE_SEQ_HDR);
        pending_bytes.push_back(PROF_MAIN10_A);
        put_code(CODE_PIC_I);
        send_pending();

        // Random buffers, with the threshold moved every dozen or so.
        sent    = 0;
        streams = 0;
        while (sent < RANDOM_BYTES) begin
            if (streams % 12 == 11)
                write_min_gap(pick_min_gap());
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            if (streams == HOLD_STREAM) begin
                // long receiver hold while one-byte buffers keep coming
                tx_idle  = 1'b0;
                hold_out = 1'b1;
                in_valid <= 1'b0;
                @(posedge i_clk);
                while (!out_held) @(posedge i_clk);
                repeat (8) begin
                    pending_bytes.push_back(8'($urandom_range(0, 255)));
                    send_pending();
                    sent++;
                end
            end
            build_random_buffer();
            sent += pending_bytes.size();
            send_pending();
            streams++;
        end

        // Last part, no idling: random buffers back to back at the reset
        // threshold.
        write_min_gap(MIN_GAP_RESET);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        while (sent < RANDOM_BYTES + TAIL_BYTES) begin
            build_random_buffer();
            sent += pending_bytes.size();
            send_pending();
        end

        settle();
        if (board.errors == 0 && board.verdicts_due.size() == 0)
            $display("avs2_stream_probe_top_test: PASS");
        else
            $display("avs2_stream_probe_top_test: FAIL");
        $finish;
    end

endmodule
